// ----- src/hex_ascii_boot_frame_receiver_unit_assert.svh -----
// Assertion macros for the boot frame receiver.
// Included by hex_ascii_boot_frame_receiver_unit; expects clk and rst in scope.
`ifndef HEX_ASCII_BOOT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define HEX_ASCII_BOOT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HABFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HABFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/habfr_pkg.sv -----
// Types and constants for the hex-ASCII boot frame receiver.
// No dependencies; imported by hex_ascii_boot_frame_receiver_unit.
`timescale 1ns / 1ps

package habfr_pkg;

  typedef enum logic [2:0] {
    PH_CONNECT = 3'd0,
    PH_ANSWER  = 3'd1,
    PH_WAIT_S  = 3'd2,
    PH_AFTER_S = 3'd3,
    PH_LOW     = 3'd4,
    PH_HIGH    = 3'd5,
    PH_TRAILER = 3'd6,
    PH_IDLE    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  localparam int OFF_W        = 6;
  localparam int BLOCK_BYTES  = 64;
  localparam int DATA_START   = 4;
  localparam int HDR_ADDR_HI  = 1;
  localparam int HDR_ADDR_LO  = 2;
  localparam int CONNECT_LEN  = 7;
  localparam int ANSWER_LEN   = 3;

  localparam logic [7:0] CH_START = 8'h53;  // 'S'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_BANG  = 8'h21;

  function automatic logic [7:0] connect_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h43;  // C
      3'd1:    ch = 8'h4F;  // O
      3'd2:    ch = 8'h4E;  // N
      3'd3:    ch = 8'h4E;  // N
      3'd4:    ch = 8'h45;  // E
      3'd5:    ch = 8'h43;  // C
      3'd6:    ch = 8'h54;  // T
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] answer_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = CH_O;
      2'd1:    ch = CH_K;
      2'd2:    ch = CH_BANG;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Arithmetic digit decode, wraps modulo 256 for non-hex characters
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_LA) d = c - CH_LA + 8'd10;
    else d = c - CH_0;
    return d;
  endfunction

endpackage

// ----- src/hex_ascii_boot_frame_receiver_unit.sv -----
// Hex-ASCII boot frame receiver: connect handshake, frame parse, flash commands.
// Depends on habfr_pkg and hex_ascii_boot_frame_receiver_unit_assert.svh.
//
//  channel | signals                                        | dir
//  rx      | rx_valid rx_stall rx_char                      | in
//  res     | res_valid res_stall kind value byte_offset     | out
//          | block_id last                                  |
//
// One character per cycle; each is decoded at its accepting edge and its
// result lands in the output register the same edge.
// The connect match makes three beats; rx stalls while the two extra answer
// characters leave the output register.
// rx stalls while a result waits in the output register and res is stalled.
// Synchronous reset returns to matching the connect string.
`timescale 1ns / 1ps

module hex_ascii_boot_frame_receiver_unit
  import habfr_pkg::*;
#(
  parameter int FRAME_BYTES = 68
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_char,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [5:0]  byte_offset,
  output logic [9:0]  block_id,
  output logic        last
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int WID_W = CNT_W + OFF_W;

  phase_t             phase, phase_next;
  logic [2:0]         match_index, match_index_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]         pending_high, pending_high_next;
  logic [7:0]         addr_high, addr_high_next;
  logic [1:0]         addr_low, addr_low_next;
  logic [1:0]         burst_left;

  logic               out_free;
  logic               rx_take;
  logic [7:0]         high_digit;
  logic [7:0]         low_digit;
  logic [7:0]         dec_byte;
  logic [WID_W-1:0]   off_wide;
  logic               in_block;
  logic [CNT_W-1:0]   count_inc;

  logic               emit;
  kind_t              emit_kind;
  logic [7:0]         emit_value;
  logic [OFF_W-1:0]   emit_offset;
  logic [9:0]         emit_block;
  logic               emit_last;
  logic               start_burst;

  assign out_free  = !res_valid || !res_stall;
  assign rx_stall  = !(out_free && (burst_left == 2'd0));
  assign rx_take   = rx_valid && !rx_stall;

  assign high_digit = digit_value(pending_high);
  assign low_digit  = digit_value(rx_char);
  assign dec_byte   = {high_digit[3:0], 4'b0000} | low_digit;
  assign off_wide  = WID_W'(byte_count) - WID_W'(DATA_START);
  assign in_block  = (byte_count >= CNT_W'(DATA_START)) &&
                     ((int'(byte_count) - DATA_START) < BLOCK_BYTES);
  assign count_inc = byte_count + 1'b1;

  // Next state
  always_comb begin
    phase_next        = phase;
    match_index_next  = match_index;
    byte_count_next   = byte_count;
    pending_high_next = pending_high;
    addr_high_next    = addr_high;
    addr_low_next     = addr_low;
    if (rx_take) begin
      unique case (phase)
        PH_CONNECT: begin
          if (rx_char == connect_char(match_index)) begin
            if (match_index == 3'(CONNECT_LEN - 1)) begin
              phase_next       = PH_ANSWER;
              match_index_next = 3'd0;
            end else begin
              match_index_next = match_index + 3'd1;
            end
          end else begin
            match_index_next = 3'd0;
          end
        end
        PH_ANSWER: begin
          if (rx_char == answer_char(match_index[1:0])) begin
            if (match_index == 3'(ANSWER_LEN - 1)) begin
              phase_next       = PH_WAIT_S;
              match_index_next = 3'd0;
            end else begin
              match_index_next = match_index + 3'd1;
            end
          end else begin
            phase_next       = PH_CONNECT;
            match_index_next = 3'd0;
          end
        end
        PH_WAIT_S: begin
          if (rx_char == CH_START) phase_next = PH_AFTER_S;
        end
        PH_AFTER_S: begin
          if (rx_char == CH_START) begin
            phase_next = PH_IDLE;
          end else begin
            pending_high_next = rx_char;
            byte_count_next   = '0;
            phase_next        = PH_LOW;
          end
        end
        PH_LOW: begin
          if (byte_count == CNT_W'(HDR_ADDR_HI)) addr_high_next = dec_byte;
          else if (byte_count == CNT_W'(HDR_ADDR_LO)) addr_low_next = dec_byte[7:6];
          byte_count_next = count_inc;
          phase_next = (count_inc >= CNT_W'(FRAME_BYTES)) ? PH_TRAILER : PH_HIGH;
        end
        PH_HIGH: begin
          pending_high_next = rx_char;
          phase_next        = PH_LOW;
        end
        PH_TRAILER: phase_next = PH_WAIT_S;
        PH_IDLE:    phase_next = PH_IDLE;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // Result of the accepted character
  always_comb begin
    emit        = 1'b0;
    emit_kind   = KIND_TX;
    emit_value  = 8'd0;
    emit_offset = '0;
    emit_block  = 10'd0;
    emit_last   = 1'b1;
    start_burst = 1'b0;
    unique case (phase)
      PH_CONNECT: begin
        if (rx_char == connect_char(match_index) &&
            match_index == 3'(CONNECT_LEN - 1)) begin
          emit        = 1'b1;
          emit_value  = CH_O;
          emit_last   = 1'b0;
          start_burst = 1'b1;
        end
      end
      PH_AFTER_S: begin
        if (rx_char == CH_START) begin
          emit      = 1'b1;
          emit_kind = KIND_END;
        end
      end
      PH_LOW: begin
        if (in_block) begin
          emit        = 1'b1;
          emit_kind   = KIND_DATA;
          emit_value  = dec_byte;
          emit_offset = off_wide[OFF_W-1:0];
          emit_block  = {addr_high, addr_low};
        end
      end
      PH_TRAILER: begin
        emit       = 1'b1;
        emit_kind  = KIND_WRITE;
        emit_block = {addr_high, addr_low};
      end
      PH_ANSWER, PH_WAIT_S, PH_HIGH, PH_IDLE: begin
        emit = 1'b0;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CONNECT;
      match_index  <= 3'd0;
      byte_count   <= '0;
      pending_high <= 8'd0;
      addr_high    <= 8'd0;
      addr_low     <= 2'd0;
    end else begin
      phase        <= phase_next;
      match_index  <= match_index_next;
      byte_count   <= byte_count_next;
      pending_high <= pending_high_next;
      addr_high    <= addr_high_next;
      addr_low     <= addr_low_next;
    end
  end

  // Output register; the answer burst drains 'K' then '!' after 'O'
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      burst_left <= 2'd0;
    end else if (out_free) begin
      if (burst_left != 2'd0) begin
        res_valid  <= 1'b1;
        burst_left <= burst_left - 2'd1;
      end else if (rx_take && emit) begin
        res_valid  <= 1'b1;
        burst_left <= start_burst ? 2'(ANSWER_LEN - 1) : 2'd0;
      end else begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (burst_left != 2'd0) begin
        kind        <= KIND_TX;
        value       <= (burst_left == 2'd2) ? CH_K : CH_BANG;
        byte_offset <= '0;
        block_id    <= 10'd0;
        last        <= (burst_left == 2'd1);
      end else if (rx_take && emit) begin
        kind        <= emit_kind;
        value       <= emit_value;
        byte_offset <= emit_offset;
        block_id    <= emit_block;
        last        <= emit_last;
      end
    end
  end

`include "hex_ascii_boot_frame_receiver_unit_assert.svh"

  `HABFR_ASSERT_SAME(a_burst_shows, burst_left != 2'd0, res_valid, "answer burst without a beat")
  `HABFR_ASSERT_SAME(a_burst_holds_rx, burst_left != 2'd0, rx_stall, "rx taken during burst")
  `HABFR_ASSERT_SAME(a_count_bound, 1'b1, byte_count <= CNT_W'(FRAME_BYTES), "frame count overrun")
  `HABFR_ASSERT_NEXT(a_end_goes_idle, rx_take && phase == PH_AFTER_S && rx_char == CH_START,
    phase == PH_IDLE && res_valid && kind == KIND_END, "session end not taken")

endmodule

// ----- sim/hex_ascii_boot_frame_receiver_unit_tb.sv -----
// Self-checking testbench for hex_ascii_boot_frame_receiver_unit.
// Drives connect/answer handshakes, hex frames and session end against a local predictor.
// Depends on habfr_pkg and the unit RTL only.
`timescale 1ns / 1ps

module hex_ascii_boot_frame_receiver_unit_tb;
  import habfr_pkg::*;

  localparam int FRAME_LEN        = 68;
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_PRINTS       = 40;

  // "CONNECT"
  localparam logic [7:0] CONNECT_TEXT [0:6] = '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54};
  localparam logic [7:0] ANSWER_TEXT [0:2] = '{CH_O, CH_K, CH_BANG};
  localparam logic [7:0] CH_C = 8'h43;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [5:0] offset;
    logic [9:0] blk;
    logic       is_last;
  } boot_cmd_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_char;
  logic       res_valid;
  logic       res_stall;
  logic [1:0] kind;
  logic [7:0] value;
  logic [5:0] byte_offset;
  logic [9:0] block_id;
  logic       last_flag;

  boot_cmd_t pending_cmds[$];

  // Predicted receiver state
  phase_t     rx_phase;
  logic [2:0] match_pos;
  int         frame_bytes_done;
  logic [7:0] high_digit_char;
  logic [7:0] addr_high;
  logic [1:0] addr_low;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  chars_sent = 0;
  int  frames_sent = 0;
  bit  calm = 1'b0;
  bit  hold_output_req = 1'b0;

  hex_ascii_boot_frame_receiver_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_char    (rx_char),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .value      (value),
    .byte_offset(byte_offset),
    .block_id   (block_id),
    .last       (last_flag)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_cmds.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch on %s at cycle %0d: expected 'h%0h, got 'h%0h", what, cycle_count,
               want, got);
  endtask

  function automatic void queue_cmd(input kind_t k, input logic [7:0] v,
                                    input logic [5:0] off, input logic [9:0] bk,
                                    input logic l);
    boot_cmd_t cmd;
    cmd.kind    = k;
    cmd.value   = v;
    cmd.offset  = off;
    cmd.blk     = bk;
    cmd.is_last = l;
    pending_cmds.push_back(cmd);
  endfunction

  function automatic void clear_receiver_state();
    rx_phase         = PH_CONNECT;
    match_pos        = 3'd0;
    frame_bytes_done = 0;
    high_digit_char  = 8'h00;
    addr_high        = 8'h00;
    addr_low         = 2'd0;
  endfunction

  // Advance the predicted state by one received character
  task automatic decode_rx_char(input logic [7:0] c);
    logic [7:0] hi_base;
    logic [7:0] lo_base;
    logic [7:0] hi_n;
    logic [7:0] lo_n;
    logic [7:0] data;
    case (rx_phase)
      PH_CONNECT: begin
        if (match_pos < 3'd7 && c == CONNECT_TEXT[match_pos]) begin
          match_pos++;
          if (match_pos == 3'd7) begin
            queue_cmd(KIND_TX, ANSWER_TEXT[0], 6'd0, 10'd0, 1'b0);
            queue_cmd(KIND_TX, ANSWER_TEXT[1], 6'd0, 10'd0, 1'b0);
            queue_cmd(KIND_TX, ANSWER_TEXT[2], 6'd0, 10'd0, 1'b1);
            rx_phase  = PH_ANSWER;
            match_pos = 3'd0;
          end
        end else begin
          match_pos = 3'd0;
        end
      end
      PH_ANSWER: begin
        if (match_pos < 3'd3 && c == ANSWER_TEXT[match_pos]) begin
          match_pos++;
          if (match_pos == 3'd3) begin
            rx_phase  = PH_WAIT_S;
            match_pos = 3'd0;
          end
        end else begin
          rx_phase  = PH_CONNECT;
          match_pos = 3'd0;
        end
      end
      PH_WAIT_S: begin
        if (c == CH_START) rx_phase = PH_AFTER_S;
      end
      PH_AFTER_S: begin
        if (c == CH_START) begin
          queue_cmd(KIND_END, 8'h00, 6'd0, 10'd0, 1'b1);
          rx_phase = PH_IDLE;
        end else begin
          high_digit_char  = c;
          frame_bytes_done = 0;
          rx_phase         = PH_LOW;
        end
      end
      PH_LOW: begin
        // Digits decode by plain subtraction, wrapping at 8 bits
        hi_base = (high_digit_char >= CH_LA) ? CH_LA - 8'd10 : CH_0;
        lo_base = (c >= CH_LA) ? CH_LA - 8'd10 : CH_0;
        hi_n = high_digit_char - hi_base;
        lo_n = c - lo_base;
        data = {hi_n[3:0], 4'h0} | lo_n;
        if (frame_bytes_done == HDR_ADDR_HI) begin
          addr_high = data;
        end else if (frame_bytes_done == HDR_ADDR_LO) begin
          addr_low = data[7:6];
        end else if (frame_bytes_done >= DATA_START &&
                     frame_bytes_done - DATA_START < BLOCK_BYTES) begin
          queue_cmd(KIND_DATA, data, 6'(frame_bytes_done - DATA_START),
                    {addr_high, addr_low}, 1'b1);
        end
        frame_bytes_done++;
        rx_phase = (frame_bytes_done >= FRAME_LEN) ? PH_TRAILER : PH_HIGH;
      end
      PH_HIGH: begin
        high_digit_char = c;
        rx_phase        = PH_LOW;
      end
      PH_TRAILER: begin
        queue_cmd(KIND_WRITE, 8'h00, 6'd0, {addr_high, addr_low}, 1'b1);
        rx_phase = PH_WAIT_S;
      end
      default: rx_phase = PH_IDLE;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one character and hold it until the beat is taken
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      rx_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_char  <= c;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    decode_rx_char(c);
    chars_sent++;
  endtask

  task automatic idle_rx();
    @(negedge clk);
    rx_valid <= 1'b0;
  endtask

  task automatic send_noise(input int n, input logic [7:0] skip);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      if (c == skip) c = ~c;
      send_char(c);
    end
  endtask

  task automatic send_connect_prefix(input int len);
    for (int i = 0; i < len; i++) send_char(CONNECT_TEXT[i]);
  endtask

  task automatic send_answer_prefix(input int len);
    for (int i = 0; i < len; i++) send_char(ANSWER_TEXT[i]);
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + {4'h0, n};
    return CH_LA + {4'h0, n} - 8'd10;
  endfunction

  // Send 'S', the frame as hex digit pairs with some non-hex noise, then the trailer
  task automatic send_frame(input logic [9:0] blk, input logic [7:0] trailer,
                            input bit with_hold);
    logic [7:0] frame_byte;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    send_char(CH_START);
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame_byte = 8'($urandom_range(0, 255));
      if (i == HDR_ADDR_HI) frame_byte = blk[9:2];
      if (i == HDR_ADDR_LO) frame_byte[7:6] = blk[1:0];
      hi_c = digit_char(frame_byte[7:4]);
      lo_c = digit_char(frame_byte[3:0]);
      if ($urandom_range(0, 9) == 0) hi_c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) lo_c = 8'($urandom_range(0, 255));
      // A second 'S' here would end the session
      if (i == 0 && hi_c == CH_START) hi_c = CH_0;
      if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      if (with_hold && i == 8) begin
        calm = 1'b0;
        hold_output_req = 1'b1;
      end
      send_char(hi_c);
      send_char(lo_c);
    end
    calm = 1'b0;
    send_char(trailer);
    frames_sent++;
  endtask

  task automatic test_connect_directed();
    send_char(8'h00);
    send_char(8'hFF);
    // Second 'C' breaks the match and is not retried
    send_char(CH_C);
    send_char(CH_C);
    // Break on the last character
    send_connect_prefix(6);
    send_char(CH_C);
    send_connect_prefix(7);
    // Answer out of order drops back to connect
    send_char(CH_K);
  endtask

  task automatic test_random_handshake();
    int k;
    logic [7:0] wrong;
    for (int round = 0; round < 2; round++) begin
      send_noise($urandom_range(0, 3), CH_C);
      k = $urandom_range(1, 6);
      send_connect_prefix(k);
      wrong = 8'($urandom_range(0, 255));
      if (wrong == CONNECT_TEXT[k]) wrong = ~wrong;
      send_char(wrong);
      send_connect_prefix(7);
      if (round == 1) begin
        send_answer_prefix(3);
      end else begin
        k = $urandom_range(0, 2);
        send_answer_prefix(k);
        wrong = 8'($urandom_range(0, 255));
        if (wrong == ANSWER_TEXT[k]) wrong = ~wrong;
        send_char(wrong);
      end
    end
  endtask

  task automatic test_frames();
    send_noise($urandom_range(1, 5), CH_START);
    send_frame(10'h3FF, CH_START, 1'b1);
  endtask

  task automatic test_session_end();
    // Pause until every outstanding result has drained
    idle_rx();
    while (pending_cmds.size() != 0) @(posedge clk);
    send_noise($urandom_range(0, 3), CH_START);
    send_char(CH_START);
    send_char(CH_START);
    // Everything after the end mark is ignored
    send_noise(8, CH_START);
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  initial begin : output_stall_gen
    int stall_left;
    int r;
    stall_left = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output_req) begin
        hold_output_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (calm || rst) begin
        res_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          res_stall <= 1'b0;
        end else begin
          res_stall <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
        end
      end
    end
  end

  always @(posedge clk) begin : result_checker
    boot_cmd_t want;
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with nothing expected, kind", 0, kind);
      end else begin
        want = pending_cmds.pop_front();
        if (kind !== want.kind) report_mismatch("kind", want.kind, kind);
        if (value !== want.value) report_mismatch("value", want.value, value);
        if (byte_offset !== want.offset)
          report_mismatch("byte_offset", want.offset, byte_offset);
        if (block_id !== want.blk) report_mismatch("block_id", want.blk, block_id);
        if (last_flag !== want.is_last) report_mismatch("last", want.is_last, last_flag);
        results_checked++;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    rx_valid = 1'b0;
    rx_char  = 8'h00;
    clear_receiver_state();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_connect_directed();
    test_random_handshake();
    test_frames();
    test_session_end();
    idle_rx();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters: broken and clean handshakes, %0d frames, session end, idle.",
             chars_sent, frames_sent);
    $display("Checked %0d results under random gaps, a long output hold and a drain pause.",
             results_checked);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
